@@ rtl/mountain_car_step_unit_assert.svh @@
// Assertion helpers used by the checker of the mountain car step unit.
`ifndef MOUNTAIN_CAR_STEP_UNIT_ASSERT_SVH
`define MOUNTAIN_CAR_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define MCS_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mountain car step unit: check failed");

// Next-cycle implication, quiet while reset is held.
`define MCS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mountain car step unit: check failed");

`endif

@@ rtl/mcs_pkg.sv @@
package mcs_pkg;

    localparam int FRAC_BITS = 28;

    // field widths
    localparam int CMD_W     = 1;
    localparam int ACT_W     = 2;
    localparam int NOISE_W   = 17;
    localparam int POS_W     = 30;
    localparam int VEL_W     = 26;
    localparam int REW_W     = 8;
    localparam int CNT_W     = 18;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    // working widths
    localparam int MAG_W   = 30;
    localparam int FORCE_W = 20;
    localparam int PROD_W  = 64;
    localparam int OPND_W  = 32;

    typedef logic signed [31:0] fix_t;

    // commands and actions
    localparam logic [CMD_W-1:0] CMD_START  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_STEP   = 1'b1;
    localparam logic [ACT_W-1:0] ACT_LEFT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RIGHT  = 2'd2;

    // rewards
    localparam logic signed [REW_W-1:0] REW_START   = 8'sd0;
    localparam logic signed [REW_W-1:0] REW_STEP    = -8'sd1;
    localparam logic signed [REW_W-1:0] REW_GOAL    = 8'sd100;
    localparam logic signed [REW_W-1:0] REW_TIMEOUT = -8'sd100;

    localparam logic [NOISE_W-1:0] NOISE_MIN = 17'd7;
    localparam logic [NOISE_W-1:0] NOISE_MAX = 17'd65536;
    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [CNT_W-1:0]   MAX_STEPS_RST = 18'd100000;

    // fixed-point constants, rounded half up
    localparam longint ONE_L   = longint'(1) << FRAC_BITS;
    localparam longint ACC_L   = (ONE_L + 500) / 1000;
    localparam longint GRAV_L  = (ONE_L * 25 + 5000) / 10000;
    localparam longint PMIN_L  = -((ONE_L * 12 + 5) / 10);
    localparam longint PMAX_L  = (ONE_L * 6 + 5) / 10;
    localparam longint VMAX_L  = (ONE_L * 7 + 50) / 100;
    localparam longint PI40_L  = 64'h3243F6A8886;
    localparam longint PI_L    =
        (PI40_L + ((longint'(1) << (40 - FRAC_BITS)) >> 1)) >> (40 - FRAC_BITS);

    localparam fix_t ONE_Q     = fix_t'(ONE_L);
    localparam fix_t ACC_Q     = fix_t'(ACC_L);
    localparam fix_t GRAV_Q    = fix_t'(GRAV_L);
    localparam fix_t PMIN_Q    = fix_t'(PMIN_L);
    localparam fix_t PMAX_Q    = fix_t'(PMAX_L);
    localparam fix_t VMAX_Q    = fix_t'(VMAX_L);
    localparam fix_t GOAL_Q    = fix_t'(ONE_L / 2);
    localparam fix_t START_Q   = fix_t'(-(ONE_L / 2));
    localparam fix_t PI_Q      = fix_t'(PI_L);
    localparam fix_t HALF_PI_Q = fix_t'(PI_L >> 1);
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(longint'(1) << (FRAC_BITS - 1));

    localparam logic signed [POS_W-1:0] POS_MIN = POS_W'(PMIN_L);
    localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(PMAX_L);

    // Horner loop: ten terms, divisor d = 2^pre * o for each term
    localparam int HTERMS = 10;
    localparam int HIDX_W = 4;
    localparam int DIV_N  = 30;

    localparam longint R95  = ((longint'(1) << (DIV_N + 7)) + 94) / 95;
    localparam longint R153 = ((longint'(1) << (DIV_N + 8)) + 152) / 153;
    localparam longint R15  = ((longint'(1) << (DIV_N + 4)) + 14) / 15;
    localparam longint R91  = ((longint'(1) << (DIV_N + 7)) + 90) / 91;
    localparam longint R33  = ((longint'(1) << (DIV_N + 6)) + 32) / 33;
    localparam longint R45  = ((longint'(1) << (DIV_N + 6)) + 44) / 45;
    localparam longint R7   = ((longint'(1) << (DIV_N + 3)) + 6) / 7;
    localparam longint R3   = ((longint'(1) << (DIV_N + 2)) + 2) / 3;
    localparam longint R1   = longint'(1) << DIV_N;

    typedef struct packed {
        logic [2:0]        pre_sh;
        logic [OPND_W-1:0] recip;
        logic [5:0]        post_sh;
    } hdiv_t;

    function automatic hdiv_t hdiv_entry(input logic [HIDX_W-1:0] idx);
        hdiv_t e;
        case (idx)
            4'd0:    e = '{pre_sh: 3'd2, recip: OPND_W'(R95),  post_sh: 6'(DIV_N + 7)};
            4'd1:    e = '{pre_sh: 3'd1, recip: OPND_W'(R153), post_sh: 6'(DIV_N + 8)};
            4'd2:    e = '{pre_sh: 3'd4, recip: OPND_W'(R15),  post_sh: 6'(DIV_N + 4)};
            4'd3:    e = '{pre_sh: 3'd1, recip: OPND_W'(R91),  post_sh: 6'(DIV_N + 7)};
            4'd4:    e = '{pre_sh: 3'd2, recip: OPND_W'(R33),  post_sh: 6'(DIV_N + 6)};
            4'd5:    e = '{pre_sh: 3'd1, recip: OPND_W'(R45),  post_sh: 6'(DIV_N + 6)};
            4'd6:    e = '{pre_sh: 3'd3, recip: OPND_W'(R7),   post_sh: 6'(DIV_N + 3)};
            4'd7:    e = '{pre_sh: 3'd1, recip: OPND_W'(R15),  post_sh: 6'(DIV_N + 4)};
            4'd8:    e = '{pre_sh: 3'd2, recip: OPND_W'(R3),   post_sh: 6'(DIV_N + 2)};
            default: e = '{pre_sh: 3'd1, recip: OPND_W'(R1),   post_sh: 6'(DIV_N)};
        endcase
        return e;
    endfunction

endpackage

@@ rtl/mountain_car_step_unit.sv @@
// Mountain car step unit: one beat on the s_ side is one command (start or step); each command
// yields exactly one result beat on the m_ side holding the new position (signed Q2.28) and
// velocity (26-bit signed, 28 fraction bits), the reward and, on tlast, the episode end flag.
// A start command resets the car to -0.5 at rest and clears the step counter. A step command
// needs cos(3*position) as a ten-term Horner series for its gravity term; every product,
// rounding and exact division by a series constant runs through one shared 32x32 multiplier.
// s_tready is high only while idle; a finished result sits in the output register and does
// not stop the next command from being taken. The user writes the max_steps register through
// cfg_valid/cfg_data (always ready) only while idle; the unit does not enforce that. A step
// whose counter passes it ends the episode with reward -100 unless the goal is reached.
module mountain_car_step_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: action [1:0], noise [18:2], zero pad [23:19]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mcs_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: command [0]
    input  logic [mcs_pkg::CMD_W-1:0]       s_tuser,
    // m_tdata: position [29:0], velocity [55:30], reward [63:56]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mcs_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tlast: terminal
    output logic                            m_tlast,
    // max_steps write port
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcs_pkg::CNT_W-1:0]       cfg_data
);
    import mcs_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_FORCE = 4'd1;
    localparam logic [ST_W-1:0] ST_ARG   = 4'd2;
    localparam logic [ST_W-1:0] ST_SQ    = 4'd3;
    localparam logic [ST_W-1:0] ST_SQR   = 4'd4;
    localparam logic [ST_W-1:0] ST_HMUL  = 4'd5;
    localparam logic [ST_W-1:0] ST_HRND  = 4'd6;
    localparam logic [ST_W-1:0] ST_HDIV  = 4'd7;
    localparam logic [ST_W-1:0] ST_HSUB  = 4'd8;
    localparam logic [ST_W-1:0] ST_GMUL  = 4'd9;
    localparam logic [ST_W-1:0] ST_GRND  = 4'd10;
    localparam logic [ST_W-1:0] ST_POS   = 4'd11;
    localparam logic [ST_W-1:0] ST_FIN   = 4'd12;

    // control state
    logic [ST_W-1:0]            state_reg, state_next;
    logic [HIDX_W-1:0]          k_reg, k_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]           max_steps_reg, max_steps_next;
    logic signed [POS_W-1:0]    pos_reg, pos_next;
    logic signed [VEL_W-1:0]    vel_reg, vel_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    // working registers
    logic [ACT_W-1:0]           action_reg, action_next;
    logic [NOISE_W-1:0]         noise_reg, noise_next;
    logic [FORCE_W-1:0]         force_reg, force_next;
    logic [MAG_W-1:0]           xmag_reg, xmag_next;
    logic                       neg_reg, neg_next;
    logic [MAG_W-1:0]           x2_reg, x2_next;
    fix_t                       t_reg, t_next;
    logic [MAG_W-1:0]           nq_reg, nq_next;
    logic signed [VEL_W-1:0]    v_reg, v_next;
    logic signed [REW_W-1:0]    reward_reg, reward_next;
    logic                       term_reg, term_next;
    logic [PROD_W-1:0]          prod_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                       m_tlast_reg, m_tlast_next;

    // shared multiplier
    logic [OPND_W-1:0]          op_a, op_b;
    logic [PROD_W-1:0]          mul_full;

    // datapath helpers
    hdiv_t                      hd;
    logic [NOISE_W-1:0]         noise_in;
    fix_t                       pos_ext, x3, xr, t_abs, q_s, g_s, f_s, v_sum, p_sum;
    logic [PROD_W-1:0]          rnd, pre_shifted, post_shifted;
    logic [35:0]                force_sum;
    logic                       gneg, accept, out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign hd       = hdiv_entry(k_reg);
    assign mul_full = op_a * op_b;

    always_comb begin
        // operand select for the shared multiplier
        t_abs = t_reg[31] ? -t_reg : t_reg;
        op_a  = '0;
        op_b  = '0;
        case (state_reg)
            ST_FORCE: begin
                op_a = OPND_W'(ACC_Q);
                op_b = OPND_W'(noise_reg);
            end
            ST_SQ: begin
                op_a = OPND_W'(xmag_reg);
                op_b = OPND_W'(xmag_reg);
            end
            ST_HMUL: begin
                op_a = OPND_W'(x2_reg);
                op_b = OPND_W'(t_abs[MAG_W-1:0]);
            end
            ST_HDIV: begin
                op_a = OPND_W'(nq_reg);
                op_b = hd.recip;
            end
            ST_GMUL: begin
                op_a = OPND_W'(GRAV_Q);
                op_b = OPND_W'(t_abs[MAG_W-1:0]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        // rounding and shifts on the registered product
        rnd          = prod_reg + HALF_LSB;
        pre_shifted  = rnd >> (6'(FRAC_BITS) + 6'(hd.pre_sh));
        post_shifted = prod_reg >> hd.post_sh;
        force_sum    = prod_reg[35:0] + 36'd32768;

        noise_in = s_tdata[NOISE_W+ACT_W-1:ACT_W];
        if (noise_in < NOISE_MIN) begin
            noise_in = NOISE_MIN;
        end else if (noise_in > NOISE_MAX) begin
            noise_in = NOISE_MAX;
        end

        // fold 3*position into [-pi/2, pi/2], noting the sign flip
        pos_ext = fix_t'(pos_reg);
        x3      = (pos_ext <<< 1) + pos_ext;
        if (x3 > HALF_PI_Q) begin
            xr = x3 - PI_Q;
        end else if (x3 < -HALF_PI_Q) begin
            xr = x3 + PI_Q;
        end else begin
            xr = x3;
        end

        q_s = fix_t'(post_shifted[MAG_W-1:0]);
        if (t_reg[31]) begin
            q_s = -q_s;
        end

        gneg = neg_reg ^ t_reg[31];
        g_s  = fix_t'(rnd[FRAC_BITS +: MAG_W]);
        if (gneg) begin
            g_s = -g_s;
        end

        f_s = '0;
        if (action_reg == ACT_LEFT) begin
            f_s = -fix_t'(force_reg);
        end else if (action_reg == ACT_RIGHT) begin
            f_s = fix_t'(force_reg);
        end

        v_sum = fix_t'(vel_reg) + f_s - g_s;
        p_sum = pos_ext + fix_t'(v_reg);
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        m_tvalid_next  = m_tvalid_reg;
        max_steps_next = max_steps_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        count_next     = count_reg;
        action_next    = action_reg;
        noise_next     = noise_reg;
        force_next     = force_reg;
        xmag_next      = xmag_reg;
        neg_next       = neg_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        nq_next        = nq_reg;
        v_next         = v_reg;
        reward_next    = reward_reg;
        term_next      = term_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        if (cfg_valid && cfg_ready) begin
            max_steps_next = cfg_data;
        end

        // drop the result once the downstream side takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_START) begin
                        pos_next    = POS_W'(START_Q);
                        vel_next    = '0;
                        count_next  = '0;
                        reward_next = REW_START;
                        term_next   = 1'b0;
                        state_next  = ST_FIN;
                    end else begin
                        action_next = s_tdata[ACT_W-1:0];
                        noise_next  = noise_in;
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                        state_next = ST_FORCE;
                    end
                end
            end
            ST_FORCE: begin
                state_next = ST_ARG;
            end
            ST_ARG: begin
                force_next = force_sum[35:16];
                neg_next   = (x3 > HALF_PI_Q) || (x3 < -HALF_PI_Q);
                xmag_next  = xr[31] ? MAG_W'(-xr) : xr[MAG_W-1:0];
                state_next = ST_SQ;
            end
            ST_SQ: begin
                state_next = ST_SQR;
            end
            ST_SQR: begin
                x2_next    = rnd[FRAC_BITS +: MAG_W];
                t_next     = ONE_Q;
                k_next     = '0;
                state_next = ST_HMUL;
            end
            ST_HMUL: begin
                state_next = ST_HRND;
            end
            ST_HRND: begin
                nq_next    = pre_shifted[MAG_W-1:0];
                state_next = ST_HDIV;
            end
            ST_HDIV: begin
                state_next = ST_HSUB;
            end
            ST_HSUB: begin
                // t = 1 - x^2 * t / d, truncated toward zero
                t_next = ONE_Q - q_s;
                if (k_reg == HIDX_W'(HTERMS - 1)) begin
                    state_next = ST_GMUL;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_HMUL;
                end
            end
            ST_GMUL: begin
                state_next = ST_GRND;
            end
            ST_GRND: begin
                if (v_sum > VMAX_Q) begin
                    v_next = VEL_W'(VMAX_Q);
                end else if (v_sum < -VMAX_Q) begin
                    v_next = VEL_W'(-VMAX_Q);
                end else begin
                    v_next = v_sum[VEL_W-1:0];
                end
                state_next = ST_POS;
            end
            ST_POS: begin
                if (p_sum > PMAX_Q) begin
                    pos_next = POS_W'(PMAX_Q);
                end else if (p_sum <= PMIN_Q) begin
                    pos_next = POS_W'(PMIN_Q);
                end else begin
                    pos_next = p_sum[POS_W-1:0];
                end
                // stop the car against the left wall
                if ((p_sum <= PMIN_Q) && v_reg[VEL_W-1]) begin
                    vel_next = '0;
                end else begin
                    vel_next = v_reg;
                end
                if (p_sum >= GOAL_Q) begin
                    reward_next = REW_GOAL;
                    term_next   = 1'b1;
                end else if (count_reg > max_steps_reg) begin
                    reward_next = REW_TIMEOUT;
                    term_next   = 1'b1;
                end else begin
                    reward_next = REW_STEP;
                    term_next   = 1'b0;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    m_tdata_next  = {reward_reg, vel_reg, pos_reg};
                    m_tlast_next  = term_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
            max_steps_reg <= MAX_STEPS_RST;
            pos_reg       <= POS_W'(START_Q);
            vel_reg       <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            m_tvalid_reg  <= m_tvalid_next;
            max_steps_reg <= max_steps_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        noise_reg   <= noise_next;
        force_reg   <= force_next;
        xmag_reg    <= xmag_next;
        neg_reg     <= neg_next;
        x2_reg      <= x2_next;
        t_reg       <= t_next;
        nq_reg      <= nq_next;
        v_reg       <= v_next;
        reward_reg  <= reward_next;
        term_reg    <= term_next;
        prod_reg    <= mul_full;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

@@ rtl/mcs_checker.sv @@
`include "mountain_car_step_unit_assert.svh"

module mcs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mcs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import mcs_pkg::*;

    logic signed [REW_W-1:0] rew;
    logic signed [POS_W-1:0] pos;

    assign rew = m_tdata[M_TDATA_W-1 -: REW_W];
    assign pos = m_tdata[POS_W-1:0];

    // one command at a time: busy right after a beat is taken
    `MCS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a stalled result holds
    `MCS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // reward and episode end agree
    `MCS_ASSERT_IMPLY(a_reward_code, aclk, aresetn, m_tvalid, ((rew == REW_START) && !m_tlast) || ((rew == REW_STEP) && !m_tlast) || ((rew == REW_GOAL) && m_tlast) || ((rew == REW_TIMEOUT) && m_tlast))

    // position stays between the walls
    `MCS_ASSERT_IMPLY(a_pos_range, aclk, aresetn, m_tvalid, (pos >= POS_MIN) && (pos <= POS_MAX))

endmodule

bind mountain_car_step_unit mcs_checker u_mcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/tb_mountain_car_step_unit.sv @@
module tb_mountain_car_step_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mcs_pkg::*;

    // Q4.28 constants, rounded half up
    localparam int     QF          = 28;
    localparam longint UNIT        = longint'(1) << QF;
    localparam longint PUSH_Q      = (UNIT + 500) / 1000;
    localparam longint GRAVITY_Q   = (UNIT * 25 + 5000) / 10000;
    localparam longint LEFT_WALL   = -((UNIT * 12 + 5) / 10);
    localparam longint RIGHT_WALL  = (UNIT * 6 + 5) / 10;
    localparam longint SPEED_CAP   = (UNIT * 7 + 50) / 100;
    localparam longint GOAL_LINE   = UNIT / 2;
    localparam longint START_POS   = -(UNIT / 2);
    localparam longint PI_40       = 64'h3243F6A8886;
    localparam longint PI_FIX      = (PI_40 + (longint'(1) << (40 - QF - 1))) >>> (40 - QF);
    localparam longint HALF_PI_FIX = PI_FIX >>> 1;

    localparam logic [ACT_W-1:0]   ACT_NONE       = 2'd1;
    localparam logic [ACT_W-1:0]   ACT_SPARE      = 2'd3;
    localparam logic [CNT_W-1:0]   LIMIT_AT_RESET = 18'd100000;
    localparam logic [NOISE_W-1:0] NOISE_FULL     = 17'd65536;
    localparam int                 CYCLE_LIMIT    = 1000000;
    localparam int                 TAIL_CYCLES    = 100;

    typedef struct {
        logic [POS_W-1:0]        pos;
        logic [VEL_W-1:0]        vel;
        logic signed [REW_W-1:0] reward;
        logic                    term;
    } car_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = CMD_START;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data = '0;

    // car state as the bench predicts it
    longint            car_pos = START_POS;
    longint            car_vel = 0;
    logic [CNT_W-1:0]  step_cnt = '0;
    logic [CNT_W-1:0]  limit_reg = LIMIT_AT_RESET;
    logic              last_terminal = 1'b0;

    car_result_t car_results_due[$];

    int  mismatch_count = 0;
    int  beat_index = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  sink_stall = 0;
    bit  src_idle = 1'b1;
    bit  snk_idle = 1'b1;

    mountain_car_step_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // action [1:0], noise [18:2], zero pad above
        .s_tuser   (s_tuser),   // command [0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // position [29:0], velocity [55:30], reward [63:56]
        .m_tlast   (m_tlast),   // terminal
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop if the block hangs or drops a beat.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, car_results_due.size());
            $display("mountain_car_step_unit test failed");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Signed Q4.28 product, round to nearest, ties away from zero.
    function automatic longint q28_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [63:0]  mag;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod + (128'd1 << (QF - 1));
        mag = prod[QF +: 64];
        mag[63:62] = 2'b00;
        return ((a < 0) != (b < 0)) ? -$signed(mag) : $signed(mag);
    endfunction

    // Fold into [-pi/2, pi/2], then a ten-term Horner series.
    function automatic longint q28_cosine(longint x);
        longint xs;
        longint xsq;
        longint t;
        bit     flip;
        int     k;
        xs = x;
        flip = 1'b0;
        t = UNIT;
        if (xs > HALF_PI_FIX) begin
            xs = xs - PI_FIX;
            flip = 1'b1;
        end else if (xs < -HALF_PI_FIX) begin
            xs = xs + PI_FIX;
            flip = 1'b1;
        end
        xsq = q28_mul(xs, xs);
        for (k = 10; k >= 1; k--)
            t = UNIT - q28_mul(xsq, t) / longint'((2 * k - 1) * (2 * k));
        return flip ? -t : t;
    endfunction

    // Advance the predicted car by one accepted command and queue its result.
    task automatic advance_car(input logic [CMD_W-1:0] cmd, input logic [ACT_W-1:0] act,
                               input logic [NOISE_W-1:0] noise);
        car_result_t r;
        longint      force_q;
        longint      v;
        longint      p;
        logic [NOISE_W-1:0] nz;
        if (cmd == CMD_START) begin
            car_pos = START_POS;
            car_vel = 0;
            step_cnt = '0;
            r.reward = REW_START;
            r.term = 1'b0;
        end else begin
            nz = noise;
            if (nz < NOISE_MIN) nz = NOISE_MIN;
            if (nz > NOISE_MAX) nz = NOISE_MAX;
            force_q = (PUSH_Q * longint'(nz) + 32768) >>> 16;
            if (step_cnt != COUNT_MAX) step_cnt = step_cnt + 1'b1;
            v = car_vel;
            if (act == ACT_LEFT) v = v - force_q;
            else if (act == ACT_RIGHT) v = v + force_q;
            v = v - q28_mul(GRAVITY_Q, q28_cosine(3 * car_pos));
            if (v > SPEED_CAP) v = SPEED_CAP;
            if (v < -SPEED_CAP) v = -SPEED_CAP;
            p = car_pos + v;
            if (p > RIGHT_WALL) p = RIGHT_WALL;
            if (p < LEFT_WALL) p = LEFT_WALL;
            // car stops dead against the left wall
            if (p == LEFT_WALL && v < 0) v = 0;
            car_pos = p;
            car_vel = v;
            r.reward = REW_STEP;
            r.term = 1'b0;
            if (p >= GOAL_LINE) begin
                r.reward = REW_GOAL;
                r.term = 1'b1;
            end else if (step_cnt > limit_reg) begin
                r.reward = REW_TIMEOUT;
                r.term = 1'b1;
            end
        end
        r.pos = car_pos[POS_W-1:0];
        r.vel = car_vel[VEL_W-1:0];
        last_terminal = r.term;
        car_results_due.push_back(r);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        $display("mismatch at result beat %0d: %s expected %0h got %0h",
                 beat_index, what, want, got);
    endtask

    // Check every result beat against the oldest prediction; drive the sink side.
    always @(posedge aclk) begin
        car_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (car_results_due.size() == 0) begin
                    flag_mismatch("result beat with nothing outstanding", 64'd0, m_tdata);
                end else begin
                    want = car_results_due.pop_front();
                    if (m_tdata[29:0] !== want.pos)
                        flag_mismatch("position", 64'(want.pos), 64'(m_tdata[29:0]));
                    if (m_tdata[55:30] !== want.vel)
                        flag_mismatch("velocity", 64'(want.vel), 64'(m_tdata[55:30]));
                    if (m_tdata[63:56] !== want.reward)
                        flag_mismatch("reward", 64'(want.reward), 64'(m_tdata[63:56]));
                    if (m_tlast !== want.term)
                        flag_mismatch("terminal", 64'(want.term), 64'(m_tlast));
                end
                beat_index++;
            end
            if (sink_stall == 0) sink_stall = pick_gap(snk_idle);
            m_tready <= (sink_stall == 0);
            if (sink_stall > 0) sink_stall--;
        end
    end

    // Offer one command beat after an optional gap; hold valid until it is taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ACT_W-1:0] act,
                             input logic [NOISE_W-1:0] noise);
        int g;
        g = pick_gap(src_idle);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({noise, act});
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        advance_car(cmd, act, noise);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic settle_outputs();
        s_tvalid <= 1'b0;
        while (car_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        settle_outputs();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        limit_reg = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ACT_W-1:0] pump_action(int wander_pct);
        if ($urandom_range(0, 99) < wander_pct) return ACT_W'($urandom_range(0, 3));
        return (car_vel >= 0) ? ACT_RIGHT : ACT_LEFT;
    endfunction

    function automatic logic [NOISE_W-1:0] pump_noise();
        if ($urandom_range(0, 99) < 85) return NOISE_W'($urandom_range(40000, 65536));
        return NOISE_W'($urandom_range(0, (1 << NOISE_W) - 1));
    endfunction

    // Reset state, ignored fields on start, noise clamping, every action code.
    task automatic test_field_extremes();
        send_item(CMD_STEP, ACT_NONE, NOISE_FULL);
        send_item(CMD_STEP, ACT_LEFT, 17'd0);
        send_item(CMD_STEP, ACT_RIGHT, 17'h1FFFF);
        send_item(CMD_STEP, ACT_SPARE, NOISE_FULL);
        send_item(CMD_STEP, ACT_RIGHT, NOISE_MIN);
        send_item(CMD_STEP, ACT_LEFT, 17'd6);
        send_item(CMD_STEP, ACT_RIGHT, 17'd65537);
        send_item(CMD_STEP, ACT_LEFT, 17'h0AAAA);
        send_item(CMD_STEP, ACT_RIGHT, 17'h15555);
        send_item(CMD_START, ACT_SPARE, 17'h1FFFF);
        send_item(CMD_STEP, ACT_RIGHT, 17'd65535);
        send_item(CMD_START, ACT_LEFT, 17'd0);
    endtask

    // A zero limit times out every step; a limit of two times out from the third.
    task automatic test_step_limit();
        write_limit('0);
        send_item(CMD_START, ACT_NONE, NOISE_FULL);
        repeat (3) send_item(CMD_STEP, ACT_RIGHT, NOISE_FULL);
        write_limit(18'd2);
        send_item(CMD_START, ACT_NONE, NOISE_FULL);
        repeat (4) send_item(CMD_STEP, ACT_LEFT, NOISE_FULL);
    endtask

    // Pump energy into the car until it reaches the goal, then keep driving it
    // past the end so the walls and the speed cap get hit.
    task automatic test_goal_runs(input logic [CNT_W-1:0] limit, input int budget,
                                  input bit idle_on);
        int stop_at;
        int n;
        write_limit(limit);
        src_idle = idle_on;
        snk_idle = idle_on;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            send_item(CMD_START, ACT_W'($urandom_range(0, 3)), pump_noise());
            for (n = 0; n < 300; n++) begin
                send_item(CMD_STEP, pump_action(8), pump_noise());
                if (last_terminal) break;
            end
            repeat ($urandom_range(15, 60)) send_item(CMD_STEP, pump_action(15), pump_noise());
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    // Short limits: episodes run just past the limit with mixed pushes.
    task automatic test_timeouts();
        int s;
        int e;
        logic [CNT_W-1:0] lim;
        for (s = 0; s < 6; s++) begin
            lim = (s == 0) ? CNT_W'(1) : CNT_W'($urandom_range(2, 30));
            write_limit(lim);
            for (e = 0; e < 2; e++) begin
                send_item(CMD_START, ACT_W'($urandom_range(0, 3)),
                          NOISE_W'($urandom_range(0, (1 << NOISE_W) - 1)));
                repeat (int'(lim) + $urandom_range(1, 6))
                    send_item(CMD_STEP, pump_action(50), pump_noise());
            end
        end
    endtask

    // Unshaped commands across the full field ranges, including restarts.
    task automatic test_random_items(input int count);
        logic [CMD_W-1:0] cmd;
        write_limit(CNT_W'($urandom_range(0, (1 << CNT_W) - 1)));
        repeat (count) begin
            cmd = ($urandom_range(0, 99) < 10) ? CMD_START : CMD_STEP;
            send_item(cmd, ACT_W'($urandom_range(0, 3)),
                      NOISE_W'($urandom_range(0, (1 << NOISE_W) - 1)));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_step_limit();
        test_goal_runs(COUNT_MAX, 450, 1'b1);
        test_goal_runs(18'd200000, 200, 1'b0);
        test_timeouts();
        test_random_items(200);

        // let the last results drain, then watch for stray beats
        settle_outputs();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("mountain_car_step_unit test passed");
        end else begin
            $display("mountain_car_step_unit test failed");
        end
        $finish;
    end

endmodule
